### rtl/lpbsc_pkg.sv
// lpbsc_pkg: shared constants, item codes and the bit-plane extract function
// for the led panel bit-plane scan controller; no dependencies
package lpbsc_pkg;

   localparam int COLUMNS       = 64;
   localparam int ROWS_SCANNED  = 32;
   localparam int PLANES        = 8;

   localparam int COL_W         = 6;
   localparam int ROW_W         = 5;
   localparam int PLANE_W       = 3;
   localparam int COLOUR_W      = 6;
   localparam int CHAN_W        = 8;
   localparam int PAIR_W        = 6 * CHAN_W;
   localparam int STORE_DEPTH   = 2048;
   localparam int STORE_ADDR_W  = $clog2(STORE_DEPTH);

   localparam int DWELL_W       = 16;
   localparam int DWELL_REGS    = 8;
   localparam int CSR_INDEX_W   = 4;

   // item kinds
   localparam logic KIND_WRITE  = 1'b0;
   localparam logic KIND_TICK   = 1'b1;

   // lane 0 is blue bottom (bits 7..0) up to lane 5 red top (bits 47..40)
   function automatic logic [COLOUR_W-1:0] plane_bits(
      input logic [PAIR_W-1:0]  pair,
      input logic [PLANE_W-1:0] plane
   );
      logic [COLOUR_W-1:0] bits;
      logic [CHAN_W-1:0]   chan;
      bits = '0;
      for (int lane = 0; lane < COLOUR_W; lane++) begin
         chan       = pair[lane*CHAN_W +: CHAN_W];
         bits[lane] = chan[plane];
      end
      return bits;
   endfunction

endpackage

### rtl/lpbsc_ram.sv
// lpbsc_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module lpbsc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/led_panel_bitplane_scan_controller.sv
// led_panel_bitplane_scan_controller: top level of the bit-plane scan controller
// depends on lpbsc_pkg and lpbsc_ram
//
// drives a row-scanned rgb led panel with binary-code modulation. a write
// transfer (kind 0) stores the six 8-bit colour values of one top/bottom
// pixel pair in a 2048 x 48 pixel store, row*64+column. a tick transfer
// (kind 1) counts the dwell counter down; when it reaches zero the plane
// advances (and the row on plane wrap), 64 result transfers follow, one per
// column, each with the six colour bits of that plane, and the last one has
// latch_now set. the counter is then reloaded from the new plane's dwell
// register. a write or a non-refreshing tick leaves the block ready for the
// next item; during a refresh no item is taken, and columns go out one per
// cycle while the receiver takes them, through the single read port of the
// pixel store. after reset the pixel store is cleared one entry per cycle,
// during which no item is taken; dwell register writes are taken at any time.
module led_panel_bitplane_scan_controller
   import lpbsc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_kind,
   input  logic [COL_W-1:0]         req_pixel_column,
   input  logic [ROW_W-1:0]         req_pixel_row,
   input  logic [CHAN_W-1:0]        req_red_top,
   input  logic [CHAN_W-1:0]        req_green_top,
   input  logic [CHAN_W-1:0]        req_blue_top,
   input  logic [CHAN_W-1:0]        req_red_bottom,
   input  logic [CHAN_W-1:0]        req_green_bottom,
   input  logic [CHAN_W-1:0]        req_blue_bottom,

   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [COL_W-1:0]         rsp_shift_column,
   output logic [COLOUR_W-1:0]      rsp_colour_bits,
   output logic [ROW_W-1:0]         rsp_row_address,
   output logic [PLANE_W-1:0]       rsp_plane_index,
   output logic                     rsp_latch_now,

   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [DWELL_W-1:0]       csr_write_data
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SHIFT
   } state_type;

   localparam logic [PLANE_W-1:0]      LAST_PLANE   = PLANE_W'(PLANES - 1);
   localparam logic [ROW_W-1:0]        LAST_ROW     = ROW_W'(ROWS_SCANNED - 1);
   localparam logic [COL_W:0]          COLUMN_COUNT = (COL_W+1)'(COLUMNS);
   localparam logic [COL_W-1:0]        LAST_COLUMN  = COL_W'(COLUMNS - 1);
   localparam logic [STORE_ADDR_W-1:0] LAST_ADDR    = STORE_ADDR_W'(STORE_DEPTH - 1);

   // control state
   state_type                 state_ff, state_in;
   logic [STORE_ADDR_W-1:0]   clear_addr_ff, clear_addr_in;
   logic [PLANE_W-1:0]        plane_ff, plane_in;
   logic [ROW_W-1:0]          row_ff, row_in;
   logic [DWELL_W-1:0]        dwell_ff, dwell_in;
   logic [COL_W:0]            issue_ff, issue_in;     // next column to read
   logic                      pending_ff, pending_in; // ram output holds an unsent column
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [DWELL_W-1:0]        dwell_reg_ff [DWELL_REGS];

   // payload registers
   logic [COL_W-1:0]          fetch_col_ff, fetch_col_in;
   logic [COL_W-1:0]          rsp_col_ff, rsp_col_in;
   logic [COLOUR_W-1:0]       rsp_colour_ff, rsp_colour_in;
   logic [ROW_W-1:0]          rsp_row_ff, rsp_row_in;
   logic [PLANE_W-1:0]        rsp_plane_ff, rsp_plane_in;
   logic                      rsp_latch_ff, rsp_latch_in;

   // pixel store ports
   logic                      ram_wr_en;
   logic [STORE_ADDR_W-1:0]   ram_wr_addr;
   logic [PAIR_W-1:0]         ram_wr_data;
   logic                      ram_rd_en;
   logic [STORE_ADDR_W-1:0]   ram_rd_addr;
   logic [PAIR_W-1:0]         ram_rd_data;

   logic                      req_take;
   logic                      move;
   logic [DWELL_W-1:0]        dwell_dec;
   logic [PLANE_W-1:0]        plane_next;
   logic [ROW_W-1:0]          row_next;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   // ram output moves into the result register when that register frees up
   assign move = pending_ff && (!rsp_valid_ff || rsp_ready);

   assign dwell_dec  = (dwell_ff == '0) ? '0 : dwell_ff - DWELL_W'(1);
   assign plane_next = (plane_ff == LAST_PLANE) ? '0 : plane_ff + PLANE_W'(1);
   always_comb begin
      row_next = row_ff;
      if (plane_ff == LAST_PLANE) begin
         row_next = (row_ff == LAST_ROW) ? '0 : row_ff + ROW_W'(1);
      end
   end

   // store writes: clearing pass, then pixel writes
   assign ram_wr_en   = (state_ff == ST_CLEAR) || (req_take && req_kind == KIND_WRITE);
   assign ram_wr_addr = (state_ff == ST_CLEAR) ? clear_addr_ff
                                               : {req_pixel_row, req_pixel_column};
   assign ram_wr_data = (state_ff == ST_CLEAR) ? '0
                        : {req_red_top, req_green_top, req_blue_top,
                           req_red_bottom, req_green_bottom, req_blue_bottom};

   // one column read per cycle while the ram output slot is free
   assign ram_rd_en   = (state_ff == ST_SHIFT) && (issue_ff < COLUMN_COUNT)
                        && (!pending_ff || move);
   assign ram_rd_addr = {row_ff, issue_ff[COL_W-1:0]};

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      plane_in      = plane_ff;
      row_in        = row_ff;
      dwell_in      = dwell_ff;
      issue_in      = issue_ff;
      pending_in    = pending_ff;
      rsp_valid_in  = rsp_valid_ff;
      fetch_col_in  = fetch_col_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_colour_in = rsp_colour_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_plane_in  = rsp_plane_ff;
      rsp_latch_in  = rsp_latch_ff;

      // result register
      if (move) begin
         rsp_valid_in  = 1'b1;
         rsp_col_in    = fetch_col_ff;
         rsp_colour_in = plane_bits(ram_rd_data, plane_ff);
         rsp_row_in    = row_ff;
         rsp_plane_in  = plane_ff;
         rsp_latch_in  = (fetch_col_ff == LAST_COLUMN);
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end

      // column fetch
      if (ram_rd_en) begin
         pending_in   = 1'b1;
         fetch_col_in = issue_ff[COL_W-1:0];
         issue_in     = issue_ff + (COL_W+1)'(1);
      end else if (move) begin
         pending_in   = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clear_addr_in = clear_addr_ff + STORE_ADDR_W'(1);
            if (clear_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && req_kind == KIND_TICK) begin
               if (dwell_dec != '0) begin
                  dwell_in = dwell_dec;
               end else begin
                  // refresh: advance plane and row, reload dwell for the new plane
                  plane_in = plane_next;
                  row_in   = row_next;
                  dwell_in = dwell_reg_ff[plane_next];
                  issue_in = '0;
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_SHIFT: begin
            if (issue_ff == COLUMN_COUNT && !pending_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         plane_ff      <= '0;
         row_ff        <= '0;
         dwell_ff      <= '0;
         issue_ff      <= '0;
         pending_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < DWELL_REGS; i++) begin
            dwell_reg_ff[i] <= DWELL_W'(1);
         end
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         plane_ff      <= plane_in;
         row_ff        <= row_in;
         dwell_ff      <= dwell_in;
         issue_ff      <= issue_in;
         pending_ff    <= pending_in;
         rsp_valid_ff  <= rsp_valid_in;
         // out-of-range register indexes are dropped
         if (csr_write_enable && csr_index < CSR_INDEX_W'(DWELL_REGS)) begin
            dwell_reg_ff[csr_index[PLANE_W-1:0]] <= csr_write_data;
         end
      end
      fetch_col_ff  <= fetch_col_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_colour_ff <= rsp_colour_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_plane_ff  <= rsp_plane_in;
      rsp_latch_ff  <= rsp_latch_in;
   end

   lpbsc_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (STORE_DEPTH)
   ) u_pixel_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shift_column = rsp_col_ff;
   assign rsp_colour_bits  = rsp_colour_ff;
   assign rsp_row_address  = rsp_row_ff;
   assign rsp_plane_index  = rsp_plane_ff;
   assign rsp_latch_now    = rsp_latch_ff;

endmodule

### tb/lpbsc_scan_checker.sv
`timescale 1ns / 1ps
// lpbsc_scan_checker: watches the request, result and register ports of the
// bit-plane scan controller, predicts every column shift and compares them
// depends on lpbsc_pkg for widths, sizes and item kinds
module lpbsc_scan_checker
   import lpbsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic                   req_kind,
   input  logic [COL_W-1:0]       req_pixel_column,
   input  logic [ROW_W-1:0]       req_pixel_row,
   input  logic [CHAN_W-1:0]      req_red_top,
   input  logic [CHAN_W-1:0]      req_green_top,
   input  logic [CHAN_W-1:0]      req_blue_top,
   input  logic [CHAN_W-1:0]      req_red_bottom,
   input  logic [CHAN_W-1:0]      req_green_bottom,
   input  logic [CHAN_W-1:0]      req_blue_bottom,

   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [COL_W-1:0]       rsp_shift_column,
   input  logic [COLOUR_W-1:0]    rsp_colour_bits,
   input  logic [ROW_W-1:0]       rsp_row_address,
   input  logic [PLANE_W-1:0]     rsp_plane_index,
   input  logic                   rsp_latch_now,

   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DWELL_W-1:0]     csr_write_data,

   output int                     fail_count,
   output int                     pending_shifts,
   output int                     refresh_count,
   output int                     shift_count,
   output logic [DWELL_W-1:0]     dwell_left,
   output logic [ROW_W-1:0]       scan_row
);

   typedef struct packed {
      logic [COL_W-1:0]    column;
      logic [COLOUR_W-1:0] colour;
      logic [ROW_W-1:0]    row;
      logic [PLANE_W-1:0]  plane;
      logic                latch;
   } column_shift_type;

   logic [PAIR_W-1:0]  pixel_mem [STORE_DEPTH];
   logic [DWELL_W-1:0] dwell_cfg [DWELL_REGS];
   int unsigned        plane_now;
   int unsigned        row_now;
   logic [DWELL_W-1:0] dwell_now;
   column_shift_type   shift_q [$];
   int                 mismatches = 0;
   int                 refreshes = 0;
   int                 shifts_seen = 0;

   task automatic check_field(input string field, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : monitor
      column_shift_type  want;
      logic [PAIR_W-1:0] pair;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++) pixel_mem[i] = '0;
         for (int i = 0; i < DWELL_REGS; i++) dwell_cfg[i] = DWELL_W'(1);
         plane_now = 0;
         row_now   = 0;
         dwell_now = '0;
         shift_q.delete();
      end else begin
         // results first: nothing accepted at this edge can show up at it
         if (rsp_valid && rsp_ready) begin
            shifts_seen++;
            if (shift_q.size() == 0) begin
               $error("column shift %0d with nothing expected", rsp_shift_column);
               mismatches++;
            end else begin
               want = shift_q.pop_front();
               check_field("shift_column", 8'(want.column), 8'(rsp_shift_column));
               check_field("colour_bits", 8'(want.colour), 8'(rsp_colour_bits));
               check_field("row_address", 8'(want.row), 8'(rsp_row_address));
               check_field("plane_index", 8'(want.plane), 8'(rsp_plane_index));
               check_field("latch_now", 8'(want.latch), 8'(rsp_latch_now));
            end
         end

         if (csr_write_enable && csr_index < DWELL_REGS)
            dwell_cfg[csr_index[PLANE_W-1:0]] = csr_write_data;

         if (req_valid && req_ready) begin
            if (req_kind == KIND_WRITE) begin
               pixel_mem[{req_pixel_row, req_pixel_column}] =
                  {req_red_top, req_green_top, req_blue_top,
                   req_red_bottom, req_green_bottom, req_blue_bottom};
            end else begin
               if (dwell_now != 0) dwell_now--;
               if (dwell_now == 0) begin
                  if (plane_now == PLANES - 1) begin
                     plane_now = 0;
                     row_now   = (row_now + 1) % ROWS_SCANNED;
                  end else begin
                     plane_now++;
                  end
                  for (int col = 0; col < COLUMNS; col++) begin
                     pair        = pixel_mem[{ROW_W'(row_now), COL_W'(col)}];
                     want.column = COL_W'(col);
                     want.colour = {pair[5*CHAN_W + plane_now], pair[4*CHAN_W + plane_now],
                                    pair[3*CHAN_W + plane_now], pair[2*CHAN_W + plane_now],
                                    pair[CHAN_W + plane_now], pair[plane_now]};
                     want.row    = ROW_W'(row_now);
                     want.plane  = PLANE_W'(plane_now);
                     want.latch  = (col == COLUMNS - 1);
                     shift_q.push_back(want);
                  end
                  dwell_now = dwell_cfg[PLANE_W'(plane_now)];
                  refreshes++;
               end
            end
         end
      end
      fail_count     <= mismatches;
      pending_shifts <= shift_q.size();
      refresh_count  <= refreshes;
      shift_count    <= shifts_seen;
      dwell_left     <= dwell_now;
      scan_row       <= ROW_W'(row_now);
   end

endmodule

### tb/led_panel_bitplane_scan_controller_test.sv
`timescale 1ns / 1ps
// led_panel_bitplane_scan_controller_test: stimulus and verdict for the scan
// controller; depends on lpbsc_pkg, the block itself and lpbsc_scan_checker
module led_panel_bitplane_scan_controller_test;
   import lpbsc_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 8;     // settling wait once every column shift is out
   localparam int TAIL_CYCLES   = 150;   // final wait before the verdict
   localparam int RANDOM_BATCH  = 28;    // random items in each of the three idling phases

   logic                   clock;
   logic                   reset;

   logic                   req_valid;
   logic                   req_ready;
   logic                   req_kind;
   logic [COL_W-1:0]       req_pixel_column;
   logic [ROW_W-1:0]       req_pixel_row;
   logic [CHAN_W-1:0]      req_red_top;
   logic [CHAN_W-1:0]      req_green_top;
   logic [CHAN_W-1:0]      req_blue_top;
   logic [CHAN_W-1:0]      req_red_bottom;
   logic [CHAN_W-1:0]      req_green_bottom;
   logic [CHAN_W-1:0]      req_blue_bottom;

   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [COL_W-1:0]       rsp_shift_column;
   logic [COLOUR_W-1:0]    rsp_colour_bits;
   logic [ROW_W-1:0]       rsp_row_address;
   logic [PLANE_W-1:0]     rsp_plane_index;
   logic                   rsp_latch_now;

   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [DWELL_W-1:0]     csr_write_data;

   // what the checker hands back
   int                     fail_count;
   int                     pending_shifts;
   int                     refresh_count;
   int                     shift_count;
   logic [DWELL_W-1:0]     dwell_left;
   logic [ROW_W-1:0]       scan_row;

   // stimulus knobs; rsp side knobs change only by nonblocking writes
   int                     req_idle_pct = 22;
   int                     rsp_idle_pct = 80;
   int                     hold_seq = 0;
   int                     hold_seen = 0;
   int                     hold_left = 0;
   int                     cycle_count = 0;
   int                     writes_sent = 0;
   int                     ticks_sent = 0;
   logic [DWELL_W-1:0]     dwell_plan [DWELL_REGS];

   led_panel_bitplane_scan_controller u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_pixel_column (req_pixel_column),
      .req_pixel_row    (req_pixel_row),
      .req_red_top      (req_red_top),
      .req_green_top    (req_green_top),
      .req_blue_top     (req_blue_top),
      .req_red_bottom   (req_red_bottom),
      .req_green_bottom (req_green_bottom),
      .req_blue_bottom  (req_blue_bottom),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_shift_column (rsp_shift_column),
      .rsp_colour_bits  (rsp_colour_bits),
      .rsp_row_address  (rsp_row_address),
      .rsp_plane_index  (rsp_plane_index),
      .rsp_latch_now    (rsp_latch_now),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   lpbsc_scan_checker u_scan_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_pixel_column (req_pixel_column),
      .req_pixel_row    (req_pixel_row),
      .req_red_top      (req_red_top),
      .req_green_top    (req_green_top),
      .req_blue_top     (req_blue_top),
      .req_red_bottom   (req_red_bottom),
      .req_green_bottom (req_green_bottom),
      .req_blue_bottom  (req_blue_bottom),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_shift_column (rsp_shift_column),
      .rsp_colour_bits  (rsp_colour_bits),
      .rsp_row_address  (rsp_row_address),
      .rsp_plane_index  (rsp_plane_index),
      .rsp_latch_now    (rsp_latch_now),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .fail_count       (fail_count),
      .pending_shifts   (pending_shifts),
      .refresh_count    (refresh_count),
      .shift_count      (shift_count),
      .dwell_left       (dwell_left),
      .scan_row         (scan_row)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // run limit, well above the slowest correct run (long dwell included)
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timed out after %0d cycles, %0d column shifts still due",
                  cycle_count, pending_shifts);
         $display("led_panel_bitplane_scan_controller_test: FAIL");
         $finish;
      end
   end

   // result side: random idling, or a long hold-off when the stimulus bumps hold_seq
   always @(posedge clock) begin
      if (hold_seen != hold_seq) begin
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   function automatic logic [CHAN_W-1:0] random_level();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return CHAN_W'($urandom);
      endcase
   endfunction

   // one request transfer; valid stays up after acceptance until the next
   // offer or pause_sender, so back-to-back transfers need no gap
   task automatic offer_item(input logic kind, input logic [COL_W-1:0] column,
                             input logic [ROW_W-1:0] row, input logic [PAIR_W-1:0] pair);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_pixel_column <= column;
      req_pixel_row    <= row;
      {req_red_top, req_green_top, req_blue_top,
       req_red_bottom, req_green_bottom, req_blue_bottom} <= pair;
      do @(posedge clock); while (!req_ready);
      if (kind == KIND_WRITE) writes_sent++;
      else ticks_sent++;
   endtask

   // a tick carries junk in its pixel fields
   task automatic send_tick();
      offer_item(KIND_TICK, COL_W'($urandom), ROW_W'($urandom),
                 {16'($urandom), 32'($urandom)});
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // sender stops until every column shift is out and the last item has settled
   task automatic drain_results();
      pause_sender();
      while (pending_shifts != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // every index is written: dwell_plan into the real registers, junk into the
   // unused ones, after the real ones so a wrong decode would overwrite them
   task automatic program_dwells();
      for (int i = 0; i < 2**CSR_INDEX_W; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_INDEX_W'(i);
         csr_write_data   <= (i < DWELL_REGS) ? dwell_plan[i] : DWELL_W'($urandom);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // half ticks, half writes aimed mostly at the row being scanned or the next one
   task automatic random_items(input int count);
      logic [ROW_W-1:0] row;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 19) == 0) drain_results();
         if ($urandom_range(0, 1) == 1) begin
            send_tick();
         end else begin
            row = ($urandom_range(0, 9) < 7) ? ROW_W'(scan_row + $urandom_range(0, 1))
                                             : ROW_W'($urandom);
            offer_item(KIND_WRITE, COL_W'($urandom), row,
                       {random_level(), random_level(), random_level(),
                        random_level(), random_level(), random_level()});
         end
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_kind         = KIND_WRITE;
      req_pixel_column = '0;
      req_pixel_row    = '0;
      req_red_top      = '0;
      req_green_top    = '0;
      req_blue_top     = '0;
      req_red_bottom   = '0;
      req_green_bottom = '0;
      req_blue_bottom  = '0;
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // phase one: sender idles a little, receiver a lot
      req_idle_pct = 22;
      rsp_idle_pct <= 80;

      // counter resets to zero, so the first tick refreshes at once, showing a
      // cleared store; it waits out the clearing pass on req_ready
      send_tick();

      // corner pixels, single-bit and all-but-one patterns, then an overwrite
      offer_item(KIND_WRITE, 0, 0, {48{1'b1}});
      offer_item(KIND_WRITE, 63, 0, {8'h80, 8'h7f, 8'h40, 8'h01, 8'hfe, 8'h00});
      offer_item(KIND_WRITE, 1, 0, {8'h7f, 8'h40, 8'h80, 8'h55, 8'haa, 8'hff});
      offer_item(KIND_WRITE, 0, 1, {48{1'b1}});
      offer_item(KIND_WRITE, 63, 1, {8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20});
      offer_item(KIND_WRITE, 63, 31, {48{1'b1}});
      offer_item(KIND_WRITE, 0, 31, {8'h80, 8'h40, 8'h7f, 8'h00, 8'hff, 8'h80});
      offer_item(KIND_WRITE, 32, 0, {48{1'b1}});
      offer_item(KIND_WRITE, 32, 0, {8'h00, 8'hc3, 8'h3c, 8'h80, 8'h40, 8'h7f});

      // reset dwell of one: every tick refreshes; runs through plane wrap into row 1
      repeat (9) send_tick();

      // mixed dwells, zero and several-tick holds
      drain_results();
      dwell_plan = '{DWELL_W'(0), DWELL_W'(1), DWELL_W'(2), DWELL_W'(3),
                     DWELL_W'(1), DWELL_W'(0), DWELL_W'(2), DWELL_W'(1)};
      program_dwells();
      repeat (6) send_tick();
      random_items(RANDOM_BATCH);

      // phase two: sender idles a lot, receiver a little
      drain_results();
      req_idle_pct = 80;
      rsp_idle_pct <= 22;
      foreach (dwell_plan[i]) dwell_plan[i] = DWELL_W'($urandom_range(0, 2));
      program_dwells();
      random_items(RANDOM_BATCH);

      // phase three: no idling; dwell zero everywhere refreshes on every tick
      drain_results();
      req_idle_pct = 0;
      rsp_idle_pct <= 0;
      foreach (dwell_plan[i]) dwell_plan[i] = '0;
      program_dwells();

      // receiver holds off while ticks keep coming, so the block backs up
      hold_seq <= hold_seq + 1;
      repeat (12) send_tick();
      drain_results();

      random_items(RANDOM_BATCH);

      // largest dwell: tick until the counter has been loaded with all ones,
      // then further ticks only count it down
      drain_results();
      foreach (dwell_plan[i]) dwell_plan[i] = '1;
      program_dwells();
      while (dwell_left != '1) begin
         send_tick();
         drain_results();
      end
      repeat (4) send_tick();

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d pixel writes and %0d ticks, %0d refreshes, %0d column shifts",
               writes_sent, ticks_sent, refresh_count, shift_count);
      $display("dwell settings 0 to 65535, plane wrap into later rows, unused register indexes");
      if (fail_count == 0 && pending_shifts == 0) begin
         $display("led_panel_bitplane_scan_controller_test: PASS");
      end else begin
         $display("led_panel_bitplane_scan_controller_test: FAIL");
      end
      $finish;
   end

endmodule
